// ===== src/gfla_pkg.sv =====
// gfla_pkg: shared widths, reset constants and operation codes for the GF(2^m)
// log/antilog arithmetic unit.
// No dependencies.
package gfla_pkg;

  localparam int FIELD_BITS_DEF = 8;
  localparam int POLY_W         = 9;
  localparam int OPER_W         = 8;
  localparam int KIND_W         = 3;
  localparam int RESULT_W       = 9;

  localparam logic [POLY_W-1:0] POLY_RESET = 9'h11D;

  localparam logic [KIND_W-1:0] KIND_MUL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SQR = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INV = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EXP = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOG = 3'd4;

endpackage

// ===== src/gf_log_antilog_arith_unit.sv =====
// gf_log_antilog_arith_unit: GF(2^m) multiply/square/inverse/exp/log unit built on
// an exponent memory and a logarithm memory, with a table-fill sequencer.
// Depends on gfla_pkg.
//
// Usage
//   Command channel: kind, operand_a, operand_b are taken at a rising edge with
//   start high and busy low. One beat may be issued every cycle while busy is low.
//   Result channel: result is shown for exactly one cycle with done high, after
//   log, exp and result registers. The receiver cannot stall; nothing backs up.
//   Configuration: poly_we with field_polynomial writes the reduction polynomial
//   at a rising edge; write only while no beat is in flight.
//   Fill: after reset and after every polynomial write busy is high while the
//   sequencer rebuilds the tables: first clearing every log memory entry,
//   then stepping alpha^i through the exponent memory and writing the log of
//   each power.
//   Pipeline: log memory read, exponent index and exp memory read, result
//   register. Throughput one beat per cycle while busy is low, set by the two
//   log read ports and the one exp read port.
//   Reset (synchronous, active high) clears the pipeline, reloads 0x11D and
//   starts a fill.
module gf_log_antilog_arith_unit
  import gfla_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   kind,
  input  logic [OPER_W-1:0]   operand_a,
  input  logic [OPER_W-1:0]   operand_b,
  output logic                done,
  output logic [RESULT_W-1:0] result,
  input  logic                poly_we,
  input  logic [POLY_W-1:0]   field_polynomial
);

  // field size is tied to the port widths, so it comes from the package
  localparam int FIELD_BITS = FIELD_BITS_DEF;
  localparam int FIELD_SIZE = 1 << FIELD_BITS;
  localparam int ORDER      = FIELD_SIZE - 1;
  localparam int LOG_W      = FIELD_BITS + 1;
  localparam int IDX_W      = FIELD_BITS + 2;
  // width wide enough for both the shifted element and the polynomial
  localparam int RED_W      = (LOG_W > POLY_W) ? LOG_W : POLY_W;

  typedef logic [FIELD_BITS-1:0] elem_t;
  typedef logic [LOG_W-1:0]      log_t;
  typedef logic [IDX_W-1:0]      idx_t;

  localparam idx_t  ORDER_IDX = idx_t'(ORDER);
  localparam elem_t CNT_LAST  = elem_t'(FIELD_SIZE - 1);
  localparam elem_t GEN_LAST  = elem_t'(ORDER - 1);
  localparam log_t  LOG_ZERO  = log_t'(FIELD_SIZE);   // log(0) by convention

  // sequencer states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_GEN   = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  elem_t             cnt;
  elem_t             cnt_next;
  elem_t             elt;
  elem_t             elt_next;
  logic [POLY_W-1:0] poly;

  // tables
  log_t  log_mem [FIELD_SIZE];
  elem_t exp_mem [FIELD_SIZE];   // entry ORDER holds alpha^0 again

  logic  log_we;
  elem_t log_wa;
  log_t  log_wd;
  logic  exp_we;
  elem_t exp_wa;
  elem_t exp_wd;

  logic  accept;
  elem_t a_elem;
  elem_t b_elem;

  // stage 1: log data back
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  elem_t             s1_a;
  logic              s1_a_zero;
  logic              s1_b_zero;
  log_t              la_q;
  log_t              lb_q;

  idx_t  sum_mul;
  idx_t  sum_sqr;
  idx_t  sum_inv;
  elem_t exp_idx;

  // stage 2: exp data back
  logic              s2_valid;
  logic [KIND_W-1:0] s2_kind;
  logic              s2_zero;
  log_t              s2_log;
  elem_t             exp_q;

  logic [RESULT_W-1:0] result_next;
  logic [RED_W-1:0]    shifted;

  assign busy   = (state != ST_RUN);
  assign accept = start && !busy;
  assign a_elem = elem_t'(operand_a);
  assign b_elem = elem_t'(operand_b);

  // --- fill sequencer -------------------------------------------------------
  always_comb begin
    shifted = RED_W'({elt, 1'b0});
    if (shifted[FIELD_BITS]) begin
      shifted = shifted ^ RED_W'(poly);
    end
    elt_next = shifted[FIELD_BITS-1:0];
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + elem_t'(1);
    unique case (state)
      ST_CLEAR: begin
        if (cnt == CNT_LAST) begin
          state_next = ST_GEN;
          cnt_next   = '0;
        end
      end
      ST_GEN: begin
        if (cnt == GEN_LAST) begin
          state_next = ST_RUN;
          cnt_next   = '0;
        end
      end
      ST_RUN: begin
        cnt_next = '0;
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      elt   <= elem_t'(1);
      poly  <= POLY_RESET;
    end else if (poly_we) begin
      state <= ST_CLEAR;
      cnt   <= '0;
      elt   <= elem_t'(1);
      poly  <= field_polynomial;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == ST_GEN) begin
        elt <= elt_next;
      end else begin
        elt <= elem_t'(1);
      end
    end
  end

  // clear pass writes log(0) at entry 0; generation skips element 0 so that
  // entry keeps log(0) even for a non-primitive polynomial
  always_comb begin
    log_we = 1'b0;
    log_wa = cnt;
    log_wd = '0;
    exp_we = 1'b0;
    exp_wa = cnt;
    exp_wd = elt;
    if (state == ST_CLEAR) begin
      log_we = 1'b1;
      log_wd = (cnt == '0) ? LOG_ZERO : '0;
      exp_we = (cnt == '0);
      exp_wa = elem_t'(ORDER);
      exp_wd = elem_t'(1);
    end else if (state == ST_GEN) begin
      log_we = (elt != '0);
      log_wa = elt;
      log_wd = log_t'(cnt);
      exp_we = 1'b1;
    end
  end

  // --- memories -------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_wa] <= log_wd;
    end
    la_q <= log_mem[a_elem];
    lb_q <= log_mem[b_elem];
  end

  always_ff @(posedge clk) begin
    if (exp_we) begin
      exp_mem[exp_wa] <= exp_wd;
    end
    exp_q <= exp_mem[exp_idx];
  end

  // --- stage 1: exponent index ---------------------------------------------
  always_comb begin
    sum_mul = idx_t'(la_q) + idx_t'(lb_q);
    if (sum_mul >= ORDER_IDX) begin
      sum_mul = sum_mul - ORDER_IDX;
    end
    sum_sqr = idx_t'({la_q, 1'b0});
    if (sum_sqr >= ORDER_IDX) begin
      sum_sqr = sum_sqr - ORDER_IDX;
    end
    sum_inv = ORDER_IDX - idx_t'(la_q);
  end

  always_comb begin
    unique case (s1_kind)
      KIND_MUL: exp_idx = sum_mul[FIELD_BITS-1:0];
      KIND_SQR: exp_idx = sum_sqr[FIELD_BITS-1:0];
      KIND_INV: exp_idx = sum_inv[FIELD_BITS-1:0];
      KIND_EXP: exp_idx = s1_a;
      default:  exp_idx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      done     <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_kind   <= kind;
    s1_a      <= a_elem;
    s1_a_zero <= (a_elem == '0);
    s1_b_zero <= (b_elem == '0);
    s2_kind   <= s1_kind;
    s2_log    <= la_q;
    s2_zero   <= s1_a_zero || ((s1_kind == KIND_MUL) && s1_b_zero);
    result    <= result_next;
  end

  // --- stage 2: result select ----------------------------------------------
  always_comb begin
    case (s2_kind) inside
      KIND_MUL, KIND_SQR, KIND_INV: begin
        result_next = s2_zero ? '0 : RESULT_W'(exp_q);
      end
      KIND_EXP: result_next = RESULT_W'(exp_q);
      KIND_LOG: result_next = RESULT_W'(s2_log);
      default:  result_next = '0;
    endcase
  end

`ifndef SYNTH
  a_done_after_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 3))
    else $error("result strobe without a matching command three cycles earlier");

  a_fill_ends_in_gen: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> ($past(state) == ST_GEN && $past(cnt) == GEN_LAST))
    else $error("busy dropped before the table fill finished");

  a_gen_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_GEN && $past(state) == ST_CLEAR) |-> (cnt == '0 && elt == elem_t'(1)))
    else $error("generation pass did not start at alpha^0");
`endif

endmodule

// ===== test/gf_log_antilog_arith_unit_test.sv =====
// gf_log_antilog_arith_unit_test: self-checking bench for the GF(2^8) log/antilog unit.
// Directed table then random beats over several field polynomials, checked by a table model.
// Depends on gfla_pkg and gf_log_antilog_arith_unit.
module gf_log_antilog_arith_unit_test;
  import gfla_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int RESET_CYCLES = 11;
  localparam int PIPE_LATENCY = 3;
  // cycles allowed after the last beat before a leftover counts as lost
  localparam int DRAIN_LIMIT  = 100;
  localparam int GROUP_ORDER  = 255;

  // kinds the unit does not implement: they must give zero
  localparam logic [KIND_W-1:0] KIND_RSV5 = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSV6 = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSV7 = 3'd7;

  localparam logic [RESULT_W-1:0] LOG_OF_ZERO = 9'd256;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind;
  logic [OPER_W-1:0]   operand_a;
  logic [OPER_W-1:0]   operand_b;
  logic                done;
  logic [RESULT_W-1:0] result;
  logic                poly_we;
  logic [POLY_W-1:0]   field_polynomial;

  gf_log_antilog_arith_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .operand_a        (operand_a),
    .operand_b        (operand_b),
    .done             (done),
    .result           (result),
    .poly_we          (poly_we),
    .field_polynomial (field_polynomial)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Table model of the field. Rebuilt whenever the polynomial changes, exactly
  // as the unit's own fill sequencer walks alpha^i: clear the log table, step
  // 255 times, then pin the three tail entries and log(0).
  // ---------------------------------------------------------------------------
  logic [7:0]          alog_tab [0:257];
  logic [RESULT_W-1:0] dlog_tab [0:255];

  function automatic void rebuild_tables(input logic [POLY_W-1:0] poly);
    logic [8:0] elt;
    elt = 9'd1;
    for (int i = 0; i < 256; i++) dlog_tab[i] = '0;
    for (int i = 0; i < GROUP_ORDER; i++) begin
      alog_tab[i] = elt[7:0];
      // later writes win when the polynomial is not primitive
      dlog_tab[elt[7:0]] = 9'(i);
      elt = {elt[7:0], 1'b0};
      if (elt[8]) begin
        elt = elt ^ poly;
      end
      // carry is dropped whether or not the polynomial had its top bit
      elt[8] = 1'b0;
    end
    alog_tab[255] = 8'd1;
    alog_tab[256] = 8'd2;
    alog_tab[257] = 8'd4;
    dlog_tab[0]   = LOG_OF_ZERO;
  endfunction

  // sums of two logs stay below twice the group order, so one subtract folds
  function automatic logic [9:0] fold_log(input logic [9:0] s);
    return (s >= 10'(GROUP_ORDER)) ? s - 10'(GROUP_ORDER) : s;
  endfunction

  function automatic logic [RESULT_W-1:0] gf_result(input logic [KIND_W-1:0] op,
                                                    input logic [7:0] a,
                                                    input logic [7:0] b);
    logic [RESULT_W-1:0] r;
    r = '0;
    case (op)
      KIND_MUL: begin
        if (a != 8'd0 && b != 8'd0) begin
          r = {1'b0, alog_tab[fold_log({1'b0, dlog_tab[a]} + {1'b0, dlog_tab[b]})]};
        end
      end
      KIND_SQR: begin
        if (a != 8'd0) begin
          r = {1'b0, alog_tab[fold_log({dlog_tab[a], 1'b0})]};
        end
      end
      KIND_INV: begin
        // zero has no inverse: defined as zero rather than reading past the table
        if (a != 8'd0) begin
          r = {1'b0, alog_tab[9'(GROUP_ORDER) - dlog_tab[a]]};
        end
      end
      KIND_EXP: r = {1'b0, alog_tab[a]};
      KIND_LOG: r = dlog_tab[a];
      default:  r = '0;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Results owed by the unit, oldest first
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [KIND_W-1:0]   op;
    logic [OPER_W-1:0]   a;
    logic [OPER_W-1:0]   b;
    logic [RESULT_W-1:0] want;
  } owed_result_t;

  owed_result_t owed_results[$];
  owed_result_t oldest;
  int           mismatch_count = 0;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Result side: done is a one-cycle strobe, sampled at the edge that ends it.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result 0x%0h with no beat outstanding", result));
      end else begin
        oldest = owed_results.pop_front();
        if (result !== oldest.want) begin
          report_mismatch($sformatf("kind %0d a 0x%0h b 0x%0h: result 0x%0h, want 0x%0h",
                                    oldest.op, oldest.a, oldest.b, result, oldest.want));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Holds a beat on the ports until the unit takes it. start is left high so
  // the next beat can follow in the very next cycle.
  task automatic issue_beat(input logic [KIND_W-1:0] op, input logic [OPER_W-1:0] a,
                            input logic [OPER_W-1:0] b, input logic typed,
                            input logic [RESULT_W-1:0] typed_want);
    owed_result_t entry;
    kind      <= op;
    operand_a <= a;
    operand_b <= b;
    start     <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    entry.op   = op;
    entry.a    = a;
    entry.b    = b;
    entry.want = typed ? typed_want : gf_result(op, a, b);
    owed_results.push_back(entry);
  endtask

  // idle_pct: chance in percent of an idle gap of random length before the next beat
  task automatic maybe_idle(input int idle_pct);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Polynomial writes only with the pipe empty; the unit then refills and
  // holds busy, which issue_beat simply waits out.
  task automatic load_field_poly(input logic [POLY_W-1:0] poly);
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 1) @(posedge clk);
    poly_we          <= 1'b1;
    field_polynomial <= poly;
    @(posedge clk);
    poly_we <= 1'b0;
    rebuild_tables(poly);
  endtask

  // Zero, one and all-ones turn up far more often than uniform picks give.
  function automatic logic [OPER_W-1:0] pick_elem();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2:       return 8'hFF;
      3:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [KIND_W-1:0] pick_kind();
    if ($urandom_range(0, 99) < 8) begin
      return KIND_W'($urandom_range(5, 7));
    end
    return KIND_W'($urandom_range(0, 4));
  endfunction

  // Random beats under the polynomial in force. Idling density is redrawn
  // every 32 beats so there are dense and sparse stretches alike.
  task automatic random_beats(input int count, input bit allow_idle);
    int idle_pct;
    idle_pct = 0;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (allow_idle) begin
        maybe_idle(idle_pct);
      end
      issue_beat(pick_kind(), pick_elem(), pick_elem(), 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run under the reset polynomial 0x11D. Expected values are
  // typed only where obvious; the rest come from the table model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [KIND_W-1:0]   op;
    logic [OPER_W-1:0]   a;
    logic [OPER_W-1:0]   b;
    logic                typed;
    logic [RESULT_W-1:0] want;
  } stim_row_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{KIND_MUL,  8'h00, 8'h00, 1'b1, 9'h000},  // zero times zero
    '{KIND_MUL,  8'h00, 8'hFF, 1'b1, 9'h000},  // zero on either side
    '{KIND_MUL,  8'hFF, 8'h00, 1'b1, 9'h000},
    '{KIND_MUL,  8'h01, 8'h01, 1'b1, 9'h001},
    '{KIND_MUL,  8'h01, 8'hFF, 1'b1, 9'h0FF},  // identity
    '{KIND_MUL,  8'h02, 8'h80, 1'b1, 9'h01D},  // alpha^8 folds to the poly tail
    '{KIND_MUL,  8'hFF, 8'hFF, 1'b0, 9'h000},  // log sum wraps the group order
    '{KIND_SQR,  8'h00, 8'hFF, 1'b1, 9'h000},
    '{KIND_SQR,  8'h01, 8'h00, 1'b1, 9'h001},
    '{KIND_SQR,  8'hFF, 8'hAA, 1'b0, 9'h000},
    '{KIND_INV,  8'h00, 8'h55, 1'b1, 9'h000},  // inverse of zero is pinned to zero
    '{KIND_INV,  8'h01, 8'hFF, 1'b1, 9'h001},
    '{KIND_INV,  8'hFF, 8'h00, 1'b0, 9'h000},
    '{KIND_EXP,  8'h00, 8'h00, 1'b1, 9'h001},
    '{KIND_EXP,  8'h01, 8'hFF, 1'b1, 9'h002},
    '{KIND_EXP,  8'h08, 8'h00, 1'b1, 9'h01D},
    '{KIND_EXP,  8'hFE, 8'h00, 1'b0, 9'h000},
    '{KIND_EXP,  8'hFF, 8'h00, 1'b1, 9'h001},  // alpha^255 wraps back to one
    '{KIND_LOG,  8'h00, 8'h00, 1'b1, LOG_OF_ZERO},
    '{KIND_LOG,  8'h01, 8'hFF, 1'b1, 9'h000},
    '{KIND_LOG,  8'h02, 8'h00, 1'b1, 9'h001},
    '{KIND_LOG,  8'hFF, 8'h00, 1'b0, 9'h000},
    '{KIND_RSV5, 8'hFF, 8'hFF, 1'b1, 9'h000},  // unused kinds give zero
    '{KIND_RSV6, 8'hAA, 8'h55, 1'b1, 9'h000},
    '{KIND_RSV7, 8'h55, 8'hAA, 1'b1, 9'h000}
  };

  // Polynomial phases: all ones, the top bit alone, a value lacking its top bit,
  // zero, a random value, several primitive ones, and the reset value last.
  localparam int N_PHASES = 8;
  localparam logic [POLY_W-1:0] PHASE_POLY [N_PHASES] = '{
    9'h1FF, 9'h100, 9'h02B, 9'h000, 9'h12B, 9'h14D, 9'h165, 9'h11D
  };
  localparam int PHASE_BEATS [N_PHASES] = '{40, 40, 60, 40, 150, 150, 150, 190};

  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    start            = 1'b0;
    kind             = KIND_MUL;
    operand_a        = '0;
    operand_b        = '0;
    poly_we          = 1'b0;
    field_polynomial = POLY_RESET;
    rebuild_tables(POLY_RESET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // the first beat waits out the fill that follows reset
    foreach (DIRECTED[i]) begin
      maybe_idle(20);
      issue_beat(DIRECTED[i].op, DIRECTED[i].a, DIRECTED[i].b,
                 DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      load_field_poly(PHASE_POLY[p]);
      // one extra phase with a random polynomial, just before the last
      if (p == N_PHASES - 1) begin
        random_beats(40, 1'b1);
        load_field_poly(POLY_W'($urandom_range(0, 511)));
        random_beats(60, 1'b1);
        load_field_poly(PHASE_POLY[p]);
      end
      // no idling at all in the closing phase
      random_beats(PHASE_BEATS[p], p != N_PHASES - 1);
    end
    start <= 1'b0;

    for (int n = 0; n < DRAIN_LIMIT && owed_results.size() != 0; n++) @(posedge clk);
    while (owed_results.size() != 0) begin
      oldest = owed_results.pop_front();
      report_mismatch($sformatf("kind %0d a 0x%0h b 0x%0h: no result seen",
                                oldest.op, oldest.a, oldest.b));
    end
    repeat (PIPE_LATENCY + 4) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: stops a run that hangs and reports it as failing.
  initial begin
    #(CLK_PERIOD * 400000);
    $display("Mismatches found");
    $finish;
  end

endmodule
